@@ rtl/pol_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and codes for the positional ordered list.
// No dependencies; imported by pol_cell and positional_ordered_list.
package pol_pkg;

    localparam int POS_W   = 6;
    localparam int CNT_W   = 7;
    localparam int DATA_W  = 32;
    localparam int STAT_W  = 2;
    localparam int FUNC_W  = 2;

    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_GET    = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_DELETE = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

    localparam logic [CNT_W-1:0] CAP_RESET = 7'd64;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [POS_W-1:0]  position;
        logic [DATA_W-1:0] value;
    } pol_in_t;

    typedef struct packed {
        logic [DATA_W-1:0] value_out;
        logic [STAT_W-1:0] status;
        logic [CNT_W-1:0]  count;
    } pol_out_t;

    // Broadcast to every cell in the chain.
    typedef struct packed {
        logic             ins;
        logic             del;
        logic [CNT_W-1:0] pos;
    } pol_ctl_t;

endpackage

@@ rtl/pol_cell.sv @@
`timescale 1ns / 1ps
// One entry of the ordered list: holds a word, shifts with its neighbors.
// Depends on pol_pkg.
module pol_cell #(
    parameter int WORD_BITS = 32,
    parameter int IDX_W     = 7,
    parameter int IDX       = 0
) (
    input  logic                  clk,
    input  pol_pkg::pol_ctl_t     ctl,
    input  logic [WORD_BITS-1:0]  new_word,
    input  logic [WORD_BITS-1:0]  lo_word,
    input  logic [WORD_BITS-1:0]  hi_word,
    output logic [WORD_BITS-1:0]  word,
    output logic [WORD_BITS-1:0]  rd_word
);
    import pol_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

    logic [WORD_BITS-1:0] word_reg;
    logic [WORD_BITS-1:0] word_next;
    logic [IDX_W-1:0]     pos_ext;
    logic                 hit;
    logic                 above;

    assign pos_ext = IDX_W'(ctl.pos);
    assign hit     = (pos_ext == MY_IDX);
    assign above   = (MY_IDX > pos_ext);

    always_comb
    begin
        word_next = word_reg;
        if (ctl.ins)
        begin
            if (hit)
                word_next = new_word;
            else if (above)
                word_next = lo_word;
        end
        else if (ctl.del)
        begin
            if (hit || above)
                word_next = hi_word;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word    = word_reg;
    // AND-OR read: only the addressed cell drives a nonzero word
    assign rd_word = hit ? word_reg : '0;

endmodule

@@ rtl/positional_ordered_list.sv @@
`timescale 1ns / 1ps
// Positional ordered list built as a chain of DEPTH word cells.
// Result: registered on the input transfer and presented in the next cycle.
// Throughput: one operation per cycle; the whole chain shifts in parallel,
// and a new item is held off only while an unaccepted result waits.
// Reset: length clears to zero, capacity to 64; cell contents are not reset.
module positional_ordered_list #(
    parameter int DEPTH     = 64,
    parameter int WORD_BITS = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [6:0]         cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  pol_pkg::pol_in_t   in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output pol_pkg::pol_out_t  out_data
);
    import pol_pkg::*;

    localparam int DBITS = $clog2(DEPTH) + 1;
    localparam int IDX_W = (DBITS > CNT_W) ? DBITS : CNT_W;
    localparam logic [IDX_W-1:0] DEPTH_W = IDX_W'(DEPTH);

    logic [CNT_W-1:0]     cap_reg;
    logic [CNT_W-1:0]     held_reg;
    logic [CNT_W-1:0]     held_next;
    logic                 out_valid_reg;
    pol_out_t             out_reg;
    pol_out_t             out_next;

    logic                 accept;
    logic [IDX_W-1:0]     held_w;
    logic [IDX_W-1:0]     cap_w;
    logic [IDX_W-1:0]     eff_cap;
    logic [CNT_W-1:0]     pos_ext;
    logic [CNT_W-1:0]     ins_pos;
    logic                 full;
    logic                 out_range;
    pol_ctl_t             ctl;
    logic [WORD_BITS-1:0] new_word;
    logic [WORD_BITS-1:0] rd_or;

    logic [WORD_BITS-1:0] cell_word [DEPTH];
    logic [WORD_BITS-1:0] cell_rd   [DEPTH];

    assign cfg_ready = 1'b1;
    assign in_stall  = out_valid_reg && out_stall;
    assign accept    = in_valid && !in_stall;

    assign held_w    = IDX_W'(held_reg);
    assign cap_w     = IDX_W'(cap_reg);
    assign eff_cap   = (cap_w > DEPTH_W) ? DEPTH_W : cap_w;
    assign full      = (held_w >= eff_cap) || (held_w >= DEPTH_W);
    assign pos_ext   = CNT_W'(in_data.position);
    assign ins_pos   = (pos_ext > held_reg) ? held_reg : pos_ext;
    assign out_range = (pos_ext >= held_reg) || (IDX_W'(pos_ext) >= DEPTH_W);
    assign new_word  = WORD_BITS'(in_data.value);

    always_comb
    begin
        ctl.ins = accept && (in_data.func == FUNC_INSERT) && !full;
        ctl.del = accept && (in_data.func == FUNC_DELETE) && !out_range;
        ctl.pos = (in_data.func == FUNC_INSERT) ? ins_pos : pos_ext;
    end

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            pol_cell #(
                .WORD_BITS (WORD_BITS),
                .IDX_W     (IDX_W),
                .IDX       (gi)
            ) u_cell (
                .clk      (clk),
                .ctl      (ctl),
                .new_word (new_word),
                .lo_word  (cell_word[(gi > 0) ? gi - 1 : gi]),
                .hi_word  (cell_word[(gi < DEPTH - 1) ? gi + 1 : gi]),
                .word     (cell_word[gi]),
                .rd_word  (cell_rd[gi])
            );
        end
    endgenerate

    always_comb
    begin
        rd_or = '0;
        for (int i = 0; i < DEPTH; i++)
            rd_or = rd_or | cell_rd[i];
    end

    always_comb
    begin
        held_next          = held_reg;
        out_next.value_out = '0;
        out_next.status    = ST_OK;
        unique case (in_data.func)
            FUNC_INSERT:
            begin
                if (full)
                    out_next.status = ST_FULL;
                else
                    held_next = held_reg + CNT_W'(1);
            end
            FUNC_GET:
            begin
                if (out_range)
                    out_next.status = ST_RANGE;
                else
                    out_next.value_out = DATA_W'(rd_or);
            end
            FUNC_DELETE:
            begin
                if (out_range)
                    out_next.status = ST_RANGE;
                else
                begin
                    out_next.value_out = DATA_W'(rd_or);
                    held_next          = held_reg - CNT_W'(1);
                end
            end
            FUNC_CLEAR:
            begin
                held_next = '0;
            end
            default:
            begin
                held_next = held_reg;
            end
        endcase
        out_next.count = held_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= CAP_RESET;
            held_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                cap_reg <= cfg_data;
            if (accept)
            begin
                held_reg      <= held_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
            out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

@@ bench/positional_ordered_list_checker.sv @@
`timescale 1ns / 1ps
// Checker for the positional ordered list: watches the capacity, item and result
// channels, keeps its own copy of the list and compares every result field by field.
// Depends on pol_pkg for the payload structs and the operation and status codes.
module positional_ordered_list_checker (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_valid,
    input  logic                      cfg_ready,
    input  logic [pol_pkg::CNT_W-1:0] cfg_data,
    input  logic                      in_valid,
    input  logic                      in_stall,
    input  pol_pkg::pol_in_t          in_data,
    input  logic                      out_valid,
    input  logic                      out_stall,
    input  pol_pkg::pol_out_t         out_data,
    output int                        errors,
    output int                        pending,
    output int                        list_len
);
    import pol_pkg::*;

    localparam int SLOTS = 64;

    logic [DATA_W-1:0] slot_word [SLOTS];
    int                slot_count = 0;
    logic [CNT_W-1:0]  cap_reg = CAP_RESET;
    pol_out_t          result_q [$];
    pol_out_t          want;
    int                err_cnt = 0;

    // Applies one operation to the shadow list and returns the result it owes.
    task automatic apply_list_op(input pol_in_t item, output pol_out_t res);
        int at;
        int lim;
        int i;
        at  = int'(item.position);
        lim = (int'(cap_reg) > SLOTS) ? SLOTS : int'(cap_reg);
        res = '0;
        case (item.func)
            FUNC_INSERT:
            begin
                if (slot_count >= lim)
                begin
                    res.status = ST_FULL;
                end
                else
                begin
                    if (at > slot_count)
                        at = slot_count;
                    for (i = slot_count; i > at; i--)
                        slot_word[i] = slot_word[i-1];
                    slot_word[at] = item.value;
                    slot_count++;
                end
            end
            FUNC_GET:
            begin
                if (at >= slot_count)
                    res.status = ST_RANGE;
                else
                    res.value_out = slot_word[at];
            end
            FUNC_DELETE:
            begin
                if (at >= slot_count)
                begin
                    res.status = ST_RANGE;
                end
                else
                begin
                    res.value_out = slot_word[at];
                    for (i = at + 1; i < slot_count; i++)
                        slot_word[i-1] = slot_word[i];
                    slot_count--;
                end
            end
            default:
            begin
                slot_count = 0;
            end
        endcase
        res.count = CNT_W'(slot_count);
    endtask

    task automatic report_field(input string field, input logic [DATA_W-1:0] exp_val,
                                input logic [DATA_W-1:0] act_val);
        $display("%0t: %s mismatch, expected %h, actual %h", $time, field, exp_val, act_val);
        err_cnt++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_count = 0;
            cap_reg    = CAP_RESET;
            result_q.delete();
        end
        else
        begin
            // results leave before the new transfer lands in the queue
            if (out_valid && !out_stall)
            begin
                if (result_q.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, out_data);
                    err_cnt++;
                end
                else
                begin
                    want = result_q.pop_front();
                    if (out_data.value_out !== want.value_out)
                        report_field("value_out", want.value_out, out_data.value_out);
                    if (out_data.status !== want.status)
                        report_field("status", DATA_W'(want.status), DATA_W'(out_data.status));
                    if (out_data.count !== want.count)
                        report_field("count", DATA_W'(want.count), DATA_W'(out_data.count));
                end
            end
            if (cfg_valid && cfg_ready)
                cap_reg = cfg_data;
            if (in_valid && !in_stall)
            begin
                apply_list_op(in_data, want);
                result_q.push_back(want);
            end
        end
        errors   <= err_cnt;
        pending  <= result_q.size();
        list_len <= slot_count;
    end

endmodule

@@ bench/positional_ordered_list_tb.sv @@
`timescale 1ns / 1ps
// Top of the positional ordered list bench: clock, reset, capacity writes and
// list operations with random idling, plus the verdict. Uses pol_pkg, the DUT
// and positional_ordered_list_checker.
module positional_ordered_list_tb;
    import pol_pkg::*;

    localparam int STALL_LIMIT = 4000;
    localparam int LONG_HOLD   = 80;

    logic              clk;
    logic              rst_n;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [CNT_W-1:0]  cfg_data;
    logic              in_valid;
    logic              in_stall;
    pol_in_t           in_data;
    logic              out_valid;
    logic              out_stall;
    pol_out_t          out_data;

    int errors;
    int pending;
    int list_len;
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int quiet_cycles = 0;
    bit long_hold    = 1'b0;

    positional_ordered_list i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    positional_ordered_list_checker i_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .errors    (errors),
        .pending   (pending),
        .list_len  (list_len)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // receiver side: random stall, or one long hold-off when requested
    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold)
            begin
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                long_hold = 1'b0;
            end
            out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("positional_ordered_list_tb failed");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_op(input logic [FUNC_W-1:0] op, input logic [POS_W-1:0] pos,
                           input logic [DATA_W-1:0] word);
        if ($urandom_range(0, 99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < tx_idle_pct);
        end
        in_valid          <= 1'b1;
        in_data.func      <= op;
        in_data.position  <= pos;
        in_data.value     <= word;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // stop offering and wait until every owed result has been taken
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [CNT_W-1:0] cap);
        drain();
        cfg_data  <= cap;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input logic [CNT_W-1:0] cap, input int items, input int tx_pct,
                             input int rx_pct, input bit pressure);
        int                left;
        int                burst;
        int                ins_pct;
        int                r;
        int                pos_top;
        logic [FUNC_W-1:0] op;
        logic [POS_W-1:0]  pos;
        write_capacity(cap);
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        left = items;
        while (left > 0)
        begin
            // bursts lean toward growing or shrinking the list
            burst = $urandom_range(16, 48);
            case ($urandom_range(0, 2))
                0:       ins_pct = 85;
                1:       ins_pct = 50;
                default: ins_pct = 20;
            endcase
            while (burst > 0 && left > 0)
            begin
                r = $urandom_range(0, 99);
                if (r < 2)
                    op = FUNC_CLEAR;
                else if (r < 2 + ins_pct)
                    op = FUNC_INSERT;
                else if ($urandom_range(0, 1) == 0)
                    op = FUNC_GET;
                else
                    op = FUNC_DELETE;
                pos_top = (list_len > 63) ? 63 : list_len;
                if ($urandom_range(0, 3) == 0)
                    pos = POS_W'($urandom_range(0, 63));
                else
                    pos = POS_W'($urandom_range(0, pos_top));
                if (pressure && left == items / 2)
                    long_hold = 1'b1;
                if (pressure && left == items / 4)
                    drain();
                send_op(op, pos, $urandom);
                burst--;
                left--;
            end
        end
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data  <= CAP_RESET;
        in_valid  <= 1'b0;
        in_data   <= '0;
        tx_idle_pct  = 26;
        rx_stall_pct = 52;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_capacity(CAP_RESET);
        send_op(FUNC_GET,    6'd0,  32'h0000_0000);   // empty list
        send_op(FUNC_DELETE, 6'd63, 32'hFFFF_FFFF);
        send_op(FUNC_INSERT, 6'd63, 32'h0000_0000);   // past the end, appends
        send_op(FUNC_INSERT, 6'd0,  32'hFFFF_FFFF);
        send_op(FUNC_INSERT, 6'd1,  32'h5A5A_A5A5);
        send_op(FUNC_GET,    6'd0,  32'h0);
        send_op(FUNC_GET,    6'd1,  32'h0);
        send_op(FUNC_GET,    6'd2,  32'h0);
        send_op(FUNC_GET,    6'd3,  32'h0);
        send_op(FUNC_DELETE, 6'd1,  32'h0);
        send_op(FUNC_DELETE, 6'd1,  32'h0);
        send_op(FUNC_GET,    6'd1,  32'h0);
        send_op(FUNC_CLEAR,  6'd0,  32'h0);
        send_op(FUNC_GET,    6'd0,  32'h0);           // stale cell behind a clear
        send_op(FUNC_INSERT, 6'd0,  32'h8000_0001);
        send_op(FUNC_GET,    6'd0,  32'h0);

        write_capacity(7'd1);
        send_op(FUNC_INSERT, 6'd0,  32'h1234_5678);   // full
        send_op(FUNC_DELETE, 6'd0,  32'h0);
        send_op(FUNC_INSERT, 6'd17, 32'hCAFE_F00D);

        write_capacity(7'd0);
        send_op(FUNC_INSERT, 6'd0,  32'h0000_0001);   // capacity zero refuses
        send_op(FUNC_GET,    6'd0,  32'h0);
        send_op(FUNC_CLEAR,  6'd42, 32'h0);
        send_op(FUNC_INSERT, 6'd0,  32'h0000_0001);

        run_phase(7'd64,  300, 26, 52, 1'b1);
        run_phase(7'd127, 300, 26, 52, 1'b0);
        // capacity likely drops below the current length here
        run_phase(7'd3,   150, 52, 26, 1'b0);
        run_phase(7'd0,    60, 52, 26, 1'b0);
        run_phase(7'd1,    60, 52, 26, 1'b0);
        run_phase(CNT_W'($urandom_range(2, 63)), 300, 0, 0, 1'b0);
        run_phase(7'd64,  300, 0, 0, 1'b0);

        drain();
        repeat (4) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("positional_ordered_list_tb passed");
        else
            $display("positional_ordered_list_tb failed");
        $finish;
    end

endmodule
